FILE: sv/dbhu_pkg.sv
// ----------------------------------------------------------------------------
// dbhu_pkg
// Shared types, codes and sizes for the debug breakpoint halt unit.
// ----------------------------------------------------------------------------
package dbhu_pkg;

    // Default ring size for breakpoint addresses.
    localparam int NUM_BREAKPOINTS_DEF = 8;

    // Field widths.
    localparam int OPCODE_W   = 4;
    localparam int ADDR_W     = 16;
    localparam int LINE_W     = 9;
    localparam int SCANBRK_W  = 10;
    localparam int CAUSE_W    = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 4;
    localparam int OUT_TDATA_W = 8;
    localparam int OUT_TUSER_W = 4;

    typedef logic [OPCODE_W-1:0]   t_opcode;
    typedef logic [CAUSE_W-1:0]    t_cause;
    typedef logic [CFG_IDX_W-1:0]  t_cfg_idx;

    // Event codes.
    localparam t_opcode OP_CPU_STEP = 4'd0;
    localparam t_opcode OP_USER     = 4'd1;
    localparam t_opcode OP_SCANLINE = 4'd2;
    localparam t_opcode OP_IRQ      = 4'd3;
    localparam t_opcode OP_DI       = 4'd4;
    localparam t_opcode OP_EI       = 4'd5;
    localparam t_opcode OP_GENERIC  = 4'd6;
    localparam t_opcode OP_ADD_BP   = 4'd7;
    localparam t_opcode OP_CLEAR    = 4'd8;
    localparam t_opcode OP_RESUME   = 4'd9;

    // Halt causes.
    localparam t_cause CAUSE_NONE     = 4'd0;
    localparam t_cause CAUSE_STEP     = 4'd1;
    localparam t_cause CAUSE_BP       = 4'd2;
    localparam t_cause CAUSE_USER     = 4'd3;
    localparam t_cause CAUSE_SCANLINE = 4'd4;
    localparam t_cause CAUSE_IRQ      = 4'd5;
    localparam t_cause CAUSE_DI       = 4'd6;
    localparam t_cause CAUSE_EI       = 4'd7;
    localparam t_cause CAUSE_GENERIC  = 4'd8;

    // Configuration register indexes.
    localparam t_cfg_idx CFG_IRQ_EN   = 2'd0;
    localparam t_cfg_idx CFG_DI_EN    = 2'd1;
    localparam t_cfg_idx CFG_EI_EN    = 2'd2;
    localparam t_cfg_idx CFG_SCAN_BRK = 2'd3;

    // Reset value of the scanline break register (-1, disabled).
    localparam logic [SCANBRK_W-1:0] SCAN_BRK_OFF = '1;

    // Controller to datapath commands.
    typedef struct packed {
        logic capture;  // latch the accepted item and its breakpoint matches
        logic execute;  // apply the latched item and load the result register
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic out_busy; // result register holds a transaction that is not taken
    } t_dp_status;

endpackage

FILE: sv/dbhu_ctrl.sv
// ----------------------------------------------------------------------------
// dbhu_ctrl
// Two-state controller: accept an item, then execute it once the result
// register can take the result.
// ----------------------------------------------------------------------------
module dbhu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dbhu_pkg::t_dp_status i_status,
    output dbhu_pkg::t_dp_cmd    o_cmd
);
    import dbhu_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_status.out_busy) begin
                    o_cmd.execute = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: sv/dbhu_dp.sv
// ----------------------------------------------------------------------------
// dbhu_dp
// Datapath: configuration registers, session flags, breakpoint ring with
// parallel comparators, halt decision and the result register.
// ----------------------------------------------------------------------------
module dbhu_dp #(
    parameter int NUM_BP = dbhu_pkg::NUM_BREAKPOINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  dbhu_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [dbhu_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  dbhu_pkg::t_dp_cmd                    i_cmd,
    output dbhu_pkg::t_dp_status                 o_status,
    input  dbhu_pkg::t_opcode                    i_opcode,
    input  logic [dbhu_pkg::ADDR_W-1:0]          i_pc,
    input  logic [dbhu_pkg::LINE_W-1:0]          i_scan_line,
    input  logic [dbhu_pkg::ADDR_W-1:0]          i_bp_address,
    input  logic                                 i_single_step,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_halt,
    output dbhu_pkg::t_cause                     o_halt_cause,
    output logic                                 o_session_running
);
    import dbhu_pkg::*;

    localparam int PTR_W = (NUM_BP > 1) ? $clog2(NUM_BP) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_BP - 1);

    // Configuration.
    logic                 r_irq_en;
    logic                 r_di_en;
    logic                 r_ei_en;
    logic [SCANBRK_W-1:0] r_scan_brk;

    // Session state and breakpoint ring.
    logic              r_running;
    logic              r_stepping;
    logic [NUM_BP-1:0] r_bp_valid;
    logic [ADDR_W-1:0] r_bp_addr [NUM_BP];
    logic [PTR_W-1:0]  r_ptr;

    // Latched item.
    t_opcode           r_op;
    logic [LINE_W-1:0] r_line;
    logic [ADDR_W-1:0] r_addr;
    logic              r_single;
    logic [NUM_BP-1:0] r_hit;

    // Result register.
    logic   r_out_valid;
    logic   r_out_halt;
    t_cause r_out_cause;
    logic   r_out_running;

    logic              n_running;
    logic              n_stepping;
    t_cause            n_cause;
    logic [NUM_BP-1:0] n_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq_en   <= 1'b0;
            r_di_en    <= 1'b0;
            r_ei_en    <= 1'b0;
            r_scan_brk <= SCAN_BRK_OFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_IRQ_EN:   r_irq_en   <= i_cfg_data[0];
                CFG_DI_EN:    r_di_en    <= i_cfg_data[0];
                CFG_EI_EN:    r_ei_en    <= i_cfg_data[0];
                CFG_SCAN_BRK: r_scan_brk <= i_cfg_data[SCANBRK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // One comparator per ring entry, registered with the item.
    always_comb begin
        for (int i = 0; i < NUM_BP; i++) begin
            n_hit[i] = r_bp_valid[i] && (r_bp_addr[i] == i_pc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_opcode;
            r_line   <= i_scan_line;
            r_addr   <= i_bp_address;
            r_single <= i_single_step;
            r_hit    <= n_hit;
        end
    end

    always_comb begin
        n_running  = r_running;
        n_stepping = r_stepping;
        n_cause    = CAUSE_NONE;
        case (r_op)
            OP_CPU_STEP: begin
                if (r_stepping || !r_running) begin
                    n_stepping = 1'b0;
                    n_cause    = CAUSE_STEP;
                end else if (|r_hit) begin
                    n_cause = CAUSE_BP;
                end
            end
            OP_USER:     n_cause = CAUSE_USER;
            OP_SCANLINE: begin
                // The line is never negative, so the disabled value cannot match.
                if ({1'b0, r_line} == r_scan_brk) begin
                    n_cause = CAUSE_SCANLINE;
                end
            end
            OP_IRQ:      if (r_irq_en) n_cause = CAUSE_IRQ;
            OP_DI:       if (r_di_en)  n_cause = CAUSE_DI;
            OP_EI:       if (r_ei_en)  n_cause = CAUSE_EI;
            OP_GENERIC:  n_cause = CAUSE_GENERIC;
            OP_ADD_BP, OP_CLEAR: begin
            end
            OP_RESUME: begin
                n_running = 1'b1;
                if (r_single) begin
                    n_stepping = 1'b1;
                end
            end
            default: begin
                n_running = 1'b0;
            end
        endcase
        if (n_cause != CAUSE_NONE) begin
            n_running = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_stepping  <= 1'b0;
            r_bp_valid  <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                r_running  <= n_running;
                r_stepping <= n_stepping;
                if (r_op == OP_ADD_BP) begin
                    r_bp_valid[r_ptr] <= 1'b1;
                    r_ptr <= (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
                end else if (r_op == OP_CLEAR) begin
                    r_bp_valid <= '0;
                    r_ptr      <= '0;
                end
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute && (r_op == OP_ADD_BP)) begin
            r_bp_addr[r_ptr] <= r_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_out_halt    <= (n_cause != CAUSE_NONE);
            r_out_cause   <= n_cause;
            r_out_running <= n_running;
        end
    end

    assign o_status.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_halt            = r_out_halt;
    assign o_halt_cause      = r_out_cause;
    assign o_session_running = r_out_running;

endmodule

FILE: sv/debug_breakpoint_halt_unit.sv
// ----------------------------------------------------------------------------
// debug_breakpoint_halt_unit
// Debug halt unit: session flags, a breakpoint ring and event-driven halts.
// ----------------------------------------------------------------------------
// Each accepted item is latched, then executed into the result register once
// that register can take it; the two-state controller takes no new item
// until the current one has been executed. A stalled result holds the
// controller in its execute state until the result register drains.
// Reset: synchronous, active low; clears the session flags, every breakpoint
// valid bit, the insert pointer, the configuration and the result valid.
// ----------------------------------------------------------------------------
module debug_breakpoint_halt_unit #(
    parameter int NUM_BREAKPOINTS = dbhu_pkg::NUM_BREAKPOINTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Configuration write port.
    input  logic                               i_cfg_we,
    input  dbhu_pkg::t_cfg_idx                 i_cfg_index,
    input  logic [dbhu_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input stream.
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: pc[15:0], scan_line[24:16], bp_address[40:25], single_step[41],
    // zero fill[47:42].
    input  logic [dbhu_pkg::IN_TDATA_W-1:0]    i_s_tdata,
    // tuser: opcode[3:0].
    input  logic [dbhu_pkg::IN_TUSER_W-1:0]    i_s_tuser,
    // Output stream.
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: halt[0], session_running[1], zero fill[7:2].
    output logic [dbhu_pkg::OUT_TDATA_W-1:0]   o_m_tdata,
    // tuser: halt_cause[3:0].
    output logic [dbhu_pkg::OUT_TUSER_W-1:0]   o_m_tuser
);
    import dbhu_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    logic   w_halt;
    t_cause w_cause;
    logic   w_running;

    // The controller only sequences the work and keeps just its state register;
    // all other state, including the configuration, lives in the datapath.
    dbhu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The breakpoint comparators run in parallel on the incoming pc and their
    // match vector is registered with the transaction, so the execute cycle
    // only has to reduce it.
    dbhu_dp #(
        .NUM_BP (NUM_BREAKPOINTS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_opcode          (i_s_tuser[OPCODE_W-1:0]),
        .i_pc              (i_s_tdata[15:0]),
        .i_scan_line       (i_s_tdata[24:16]),
        .i_bp_address      (i_s_tdata[40:25]),
        .i_single_step     (i_s_tdata[41]),
        .o_out_valid       (o_m_tvalid),
        .i_out_ready       (i_m_tready),
        .o_halt            (w_halt),
        .o_halt_cause      (w_cause),
        .o_session_running (w_running)
    );

    // Pack the result fields, lowest bit first, with zero fill above.
    assign o_m_tdata = {{(OUT_TDATA_W-2){1'b0}}, w_running, w_halt};
    assign o_m_tuser = w_cause;

endmodule

FILE: sv/dbhu_checker.sv
// ----------------------------------------------------------------------------
// dbhu_checker
// Port-level checks for the debug breakpoint halt unit, bound to the top.
// ----------------------------------------------------------------------------
module dbhu_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [dbhu_pkg::OUT_TDATA_W-1:0] o_m_tdata,
    input logic [dbhu_pkg::OUT_TUSER_W-1:0] o_m_tuser
);
    import dbhu_pkg::*;

    // A result that is not taken keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser)))
        else $error("result changed while stalled");

    // The halt flag agrees with the cause code.
    a_halt_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[0] == (o_m_tuser != CAUSE_NONE)))
        else $error("halt flag and cause disagree");

    // A halting transaction always leaves the session stopped.
    a_halt_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> !o_m_tdata[1])
        else $error("halt reported with session running");

    // One transaction in work at a time: no accept in the cycle after one.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while an item is in work");

    // Reset empties the result register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind debug_breakpoint_halt_unit dbhu_checker u_dbhu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

FILE: dv/debug_breakpoint_halt_unit_test.sv
// ----------------------------------------------------------------------------
// debug_breakpoint_halt_unit_test
// Self-checking bench for the debug breakpoint halt unit. Event transactions
// are driven on the input stream with random gaps. A scoreboard class keeps
// its own copy of the session flags, the breakpoint ring and the break
// enables, predicts one result per accepted event, and compares every
// result transaction with the oldest prediction. The receiver stalls at
// random and holds off once for a long stretch so the unit backs up.
// ----------------------------------------------------------------------------
module debug_breakpoint_halt_unit_test;
    import dbhu_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int RESET_LEN   = 6;
    localparam int NUM_PHASES  = 7;
    localparam int PHASE_LEN   = 100;
    localparam int LONG_HOLD   = 300;
    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_REPORTS = 10;
    localparam int NUM_CAUSES  = 9;
    localparam int POOL_SIZE   = 6;

    // Codes 10 to 15 carry no defined event; the unit treats them all alike.
    localparam t_opcode OP_UNKNOWN_LO = 4'd10;
    localparam t_opcode OP_UNKNOWN_HI = 4'd15;

    // Scanline break settings written by value.
    localparam logic [SCANBRK_W-1:0] SCAN_BRK_ZERO = 10'd0;
    localparam logic [SCANBRK_W-1:0] SCAN_BRK_TOP  = 10'd511;

    // One predicted result transaction.
    typedef struct packed {
        logic   halt;
        t_cause cause;
        logic   running;
    } t_halt_result;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the halt decision of each accepted event and holds
    // the predictions until the matching result transaction comes out.
    // ------------------------------------------------------------------------
    class halt_scoreboard;
        logic                  irq_en;
        logic                  di_en;
        logic                  ei_en;
        logic [SCANBRK_W-1:0]  scan_brk;
        logic                  running;
        logic                  stepping;
        logic [NUM_BREAKPOINTS_DEF-1:0] bp_valid;
        logic [ADDR_W-1:0]     bp_addr [NUM_BREAKPOINTS_DEF];
        int                    insert_ptr;
        t_halt_result          pending_results[$];
        int                    mismatches;
        int                    checked;
        int                    cause_hits [NUM_CAUSES];

        function new();
            irq_en     = 1'b0;
            di_en      = 1'b0;
            ei_en      = 1'b0;
            scan_brk   = SCAN_BRK_OFF;
            running    = 1'b0;
            stepping   = 1'b0;
            bp_valid   = '0;
            insert_ptr = 0;
            mismatches = 0;
            checked    = 0;
            foreach (cause_hits[i]) cause_hits[i] = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_IRQ_EN:   irq_en   = value[0];
                CFG_DI_EN:    di_en    = value[0];
                CFG_EI_EN:    ei_en    = value[0];
                CFG_SCAN_BRK: scan_brk = value[SCANBRK_W-1:0];
                default: ;
            endcase
        endfunction

        // Applies one accepted event to the shadow state and queues the result.
        function void note_event(t_opcode op, logic [ADDR_W-1:0] pc,
                                 logic [LINE_W-1:0] line, logic [ADDR_W-1:0] addr,
                                 logic single);
            t_cause       cause;
            t_halt_result res;
            cause = CAUSE_NONE;
            case (op)
                OP_CPU_STEP: begin
                    // A pending step or an idle session wins over breakpoints.
                    if (stepping || !running) begin
                        stepping = 1'b0;
                        cause = CAUSE_STEP;
                    end else begin
                        for (int i = 0; i < NUM_BREAKPOINTS_DEF; i++)
                            if (bp_valid[i] && bp_addr[i] == pc) cause = CAUSE_BP;
                    end
                end
                OP_USER:     cause = CAUSE_USER;
                // The line is unsigned, so a negative setting never matches.
                OP_SCANLINE: if ({1'b0, line} == scan_brk) cause = CAUSE_SCANLINE;
                OP_IRQ:      if (irq_en) cause = CAUSE_IRQ;
                OP_DI:       if (di_en) cause = CAUSE_DI;
                OP_EI:       if (ei_en) cause = CAUSE_EI;
                OP_GENERIC:  cause = CAUSE_GENERIC;
                OP_ADD_BP: begin
                    bp_addr[insert_ptr]  = addr;
                    bp_valid[insert_ptr] = 1'b1;
                    insert_ptr = (insert_ptr == NUM_BREAKPOINTS_DEF - 1) ? 0 : insert_ptr + 1;
                end
                OP_CLEAR: begin
                    bp_valid   = '0;
                    insert_ptr = 0;
                end
                OP_RESUME: begin
                    running = 1'b1;
                    if (single) stepping = 1'b1;
                end
                default: running = 1'b0;
            endcase
            if (cause != CAUSE_NONE) running = 1'b0;
            res.halt    = (cause != CAUSE_NONE);
            res.cause   = cause;
            res.running = running;
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] tdata,
                                   logic [OUT_TUSER_W-1:0] tuser);
            t_halt_result want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result with nothing expected: halt %0b cause %0d running %0b",
                             tdata[0], tuser, tdata[1]);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (want.cause < NUM_CAUSES) cause_hits[want.cause]++;
            if (tdata[0] !== want.halt || tuser !== want.cause || tdata[1] !== want.running)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result %0d: expected halt %0b cause %0d running %0b, got %0b %0d %0b",
                             checked, want.halt, want.cause, want.running,
                             tdata[0], tuser, tdata[1]);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the unit under test. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_cfg_we    = 1'b0;
    t_cfg_idx                i_cfg_index = CFG_IRQ_EN;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                    i_s_tvalid  = 1'b0;
    logic                    o_s_tready;
    // tdata: pc[15:0], scan_line[24:16], bp_address[40:25], single_step[41].
    logic [IN_TDATA_W-1:0]   i_s_tdata   = '0;
    // tuser: opcode[3:0].
    logic [IN_TUSER_W-1:0]   i_s_tuser   = '0;
    logic                    o_m_tvalid;
    logic                    i_m_tready  = 1'b0;
    // tdata: halt[0], session_running[1].
    logic [OUT_TDATA_W-1:0]  o_m_tdata;
    // tuser: halt_cause[3:0].
    logic [OUT_TUSER_W-1:0]  o_m_tuser;

    debug_breakpoint_halt_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    halt_scoreboard    sb;
    int                events_sent    = 0;
    int                settings_used  = 0;
    int                cycle_count    = 0;
    int                hold_requests  = 0;
    int                holds_served   = 0;
    int                stall_left     = 0;
    int                ready_left     = 0;
    int                ready_pick;
    bit                no_gaps        = 1'b0;
    logic [ADDR_W-1:0] addr_pool [POOL_SIZE];

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, sb.pending_results.size());
            $display("[debug_breakpoint_halt_unit] ERROR");
            $finish;
        end
    end

    // Receiver: checks each result transaction at the edge where it is taken,
    // then decides tready for the next cycle. Runs of steady readiness
    // alternate with short stalls and the odd long one. A long hold-off asked
    // for by the stimulus overrides whatever pattern is in progress.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata, o_m_tuser);
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            ready_left   = 0;
            stall_left   = LONG_HOLD;
        end
        if (stall_left > 0) begin
            i_m_tready <= 1'b0;
            stall_left--;
        end else if (ready_left > 0) begin
            i_m_tready <= 1'b1;
            ready_left--;
        end else begin
            ready_pick = $urandom_range(0, 9);
            if (ready_pick < 6) ready_left = $urandom_range(1, 30);
            else if (ready_pick < 9) stall_left = $urandom_range(1, 3);
            else stall_left = $urandom_range(15, 50);
            i_m_tready <= (ready_pick < 6);
        end
    end

    // Gap after an accepted event: mostly none, sometimes short, rarely long.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one event and holds it until the unit takes it. tvalid stays high
    // when the next event follows at once, so it is never dropped and raised
    // again within one step.
    task automatic send_event(t_opcode op, logic [ADDR_W-1:0] pc, logic [LINE_W-1:0] line,
                              logic [ADDR_W-1:0] addr, logic single);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= IN_TDATA_W'({single, addr, line, pc});
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_event(op, pc, line, addr, single);
        events_sent++;
        gap = random_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Stops offering and waits until every predicted result has been taken.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.write_reg(idx, value);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(logic irq_en, logic di_en, logic ei_en,
                                  logic [SCANBRK_W-1:0] scan_brk);
        write_reg(CFG_IRQ_EN, CFG_DATA_W'(irq_en));
        write_reg(CFG_DI_EN, CFG_DATA_W'(di_en));
        write_reg(CFG_EI_EN, CFG_DATA_W'(ei_en));
        write_reg(CFG_SCAN_BRK, CFG_DATA_W'(scan_brk));
        settings_used++;
    endtask

    // Random event, weighted toward well-formed debug sessions: resumes keep the
    // session running, and half the steps and most inserts reuse a small address
    // pool so breakpoint hits are common. Every field still gets random bits.
    task automatic send_random_event();
        int                r;
        t_opcode           op;
        logic [ADDR_W-1:0] pc;
        logic [LINE_W-1:0] line;
        logic [ADDR_W-1:0] addr;
        r    = $urandom_range(0, 99);
        pc   = $urandom_range(0, 16'hFFFF);
        line = $urandom_range(0, 9'h1FF);
        addr = $urandom_range(0, 16'hFFFF);
        if (r < 22) op = OP_RESUME;
        else if (r < 55) op = OP_CPU_STEP;
        else if (r < 67) op = OP_ADD_BP;
        else if (r < 70) op = OP_CLEAR;
        else if (r < 75) op = OP_SCANLINE;
        else if (r < 80) op = OP_IRQ;
        else if (r < 85) op = OP_DI;
        else if (r < 90) op = OP_EI;
        else if (r < 93) op = OP_USER;
        else if (r < 96) op = OP_GENERIC;
        else op = t_opcode'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
        if ($urandom_range(0, 1)) pc = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        if ($urandom_range(0, 3) != 0) addr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        // Aim at the configured line half the time when one is set.
        if (!sb.scan_brk[SCANBRK_W-1] && $urandom_range(0, 1))
            line = sb.scan_brk[LINE_W-1:0];
        send_event(op, pc, line, addr, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        logic irq_en;
        logic di_en;
        logic ei_en;
        logic [SCANBRK_W-1:0] scan_brk;
        sb = new();
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset configuration: all break enables off.
        // A step with no session running halts at once.
        send_event(OP_CPU_STEP, 16'h1234, 9'd0, 16'h0000, 1'b0);
        send_event(OP_RESUME, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_CPU_STEP, 16'h0000, 9'd0, 16'h0000, 1'b0);
        // Extreme addresses into the ring, then a breakpoint hit.
        send_event(OP_ADD_BP, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_ADD_BP, 16'h0000, 9'd0, 16'hFFFF, 1'b0);
        send_event(OP_RESUME, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_CPU_STEP, 16'hFFFF, 9'd0, 16'h0000, 1'b0);
        // Single step: the armed step wins over a breakpoint at the same pc.
        send_event(OP_RESUME, 16'hFFFF, 9'h1FF, 16'hFFFF, 1'b1);
        send_event(OP_CPU_STEP, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_RESUME, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_CPU_STEP, 16'h0000, 9'd0, 16'h0000, 1'b0);
        // Unconditional halts and events that are disabled at reset.
        send_event(OP_USER, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_RESUME, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_SCANLINE, 16'h0000, 9'h1FF, 16'h0000, 1'b0);
        send_event(OP_IRQ, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_DI, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_EI, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_GENERIC, 16'h0000, 9'd0, 16'h0000, 1'b0);
        // Unknown codes drop the session without a halt.
        send_event(OP_RESUME, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_UNKNOWN_HI, 16'hFFFF, 9'h1FF, 16'hFFFF, 1'b1);
        send_event(OP_RESUME, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_UNKNOWN_LO, 16'h0000, 9'd0, 16'h0000, 1'b0);
        // A clear leaves stale addresses behind that must no longer hit.
        send_event(OP_CLEAR, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_RESUME, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_CPU_STEP, 16'hFFFF, 9'd0, 16'h0000, 1'b0);
        // Overfill the ring by one: the oldest address is overwritten.
        for (int i = 0; i <= NUM_BREAKPOINTS_DEF; i++)
            send_event(OP_ADD_BP, 16'h0000, 9'd0, ADDR_W'(16'h0100 + i), 1'b0);
        send_event(OP_CPU_STEP, 16'h0100, 9'd0, 16'h0000, 1'b0);
        send_event(OP_CPU_STEP, 16'h0101, 9'd0, 16'h0000, 1'b0);
        send_event(OP_RESUME, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_CPU_STEP, 16'h0101, 9'd0, 16'h0000, 1'b0);
        wait_idle();

        // Every enable on, scanline break at its top value.
        write_all_regs(1'b1, 1'b1, 1'b1, SCAN_BRK_TOP);
        send_event(OP_IRQ, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_RESUME, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_DI, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_RESUME, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_EI, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_RESUME, 16'h0000, 9'd0, 16'h0000, 1'b0);
        send_event(OP_SCANLINE, 16'h0000, 9'h0FF, 16'h0000, 1'b0);
        send_event(OP_SCANLINE, 16'h0000, 9'h1FF, 16'h0000, 1'b0);
        wait_idle();

        // Random phases, each under a fresh register setting. The first ones
        // pin the extremes; the fourth is a back-to-back burst that runs into
        // a long receiver hold-off so the unit fills and stalls its input.
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            irq_en   = 1'($urandom_range(0, 1));
            di_en    = 1'($urandom_range(0, 1));
            ei_en    = 1'($urandom_range(0, 1));
            scan_brk = ($urandom_range(0, 3) == 0) ? SCAN_BRK_OFF
                                                   : SCANBRK_W'($urandom_range(0, 511));
            case (phase)
                0: write_all_regs(1'b0, 1'b0, 1'b0, SCAN_BRK_ZERO);
                1: write_all_regs(1'b1, 1'b0, 1'b1, SCAN_BRK_OFF);
                2: write_all_regs(1'b0, 1'b1, 1'b0, SCAN_BRK_TOP);
                default: write_all_regs(irq_en, di_en, ei_en, scan_brk);
            endcase
            addr_pool[0] = 16'h0000;
            addr_pool[1] = 16'hFFFF;
            for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = $urandom_range(0, 16'hFFFF);
            no_gaps = (phase == 3) || (phase == 5);
            if (phase == 3) hold_requests++;
            for (int n = 0; n < PHASE_LEN; n++) send_random_event();
            no_gaps = 1'b0;
            wait_idle();
        end

        // Let any stray result show up before the verdict.
        repeat (10) @(posedge i_clk);
        $display("covered %0d events under %0d register settings, %0d results checked",
                 events_sent, settings_used, sb.checked);
        $display("halts seen: step %0d, breakpoint %0d, scanline %0d, irq %0d, di %0d, ei %0d",
                 sb.cause_hits[CAUSE_STEP], sb.cause_hits[CAUSE_BP],
                 sb.cause_hits[CAUSE_SCANLINE], sb.cause_hits[CAUSE_IRQ],
                 sb.cause_hits[CAUSE_DI], sb.cause_hits[CAUSE_EI]);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
            $display("[debug_breakpoint_halt_unit] OK");
        end else begin
            $display("%0d mismatches, %0d results never seen",
                     sb.mismatches, sb.pending_results.size());
            $display("[debug_breakpoint_halt_unit] ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/dbhu_pkg.sv
sv/dbhu_ctrl.sv
sv/dbhu_dp.sv
sv/debug_breakpoint_halt_unit.sv
sv/dbhu_checker.sv
dv/debug_breakpoint_halt_unit_test.sv
